// File: src/amts_pkg.sv
`default_nettype none

package amts_pkg;

    // Shared divider widths: 16-bit dividend/quotient, 10-bit divisor
    localparam int QUO_W = 16;
    localparam int DVS_W = 10;
    localparam int STEP_W = 4;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INTERVAL,
        ST_STROBE,
        ST_EMIT
    } seq_state_t;

    // Register index (byte address / 4)
    typedef enum logic [2:0] {
        REG_BPM         = 3'd0,
        REG_METER       = 3'd1,
        REG_STROBE_DIV  = 3'd2,
        REG_LOW_FREQ    = 3'd3,
        REG_HIGH_FREQ   = 3'd4,
        REG_LOW_EN      = 3'd5,
        REG_HIGH_EN     = 3'd6,
        REG_STROBE_EN   = 3'd7
    } cfg_index_t;

    // Meter codes
    localparam logic [2:0] METER_FREE        = 3'd0;
    localparam logic [2:0] METER_FOUR_FOUR   = 3'd1;
    localparam logic [2:0] METER_THREE_FOUR  = 3'd2;
    localparam logic [2:0] METER_SIX_EIGHT   = 3'd3;
    localparam logic [2:0] METER_TWO_FOUR    = 3'd4;

    // Timing and tone constants
    localparam logic [QUO_W-1:0] MINUTE_MS    = 16'd60000;
    localparam logic [17:0]      ACCENT_ONE   = 18'd15000;
    localparam logic [17:0]      ACCENT_SIX   = 18'd7000;
    localparam logic [17:0]      ACCENT_THREE = 18'd4000;
    localparam logic [16:0]      TONE_MAX     = 17'd131071;
    localparam logic [7:0]       STROBE_DUTY  = 8'd150;

    // Reset values
    localparam logic [9:0]  BPM_RST        = 10'd120;
    localparam logic [7:0]  STROBE_DIV_RST = 8'd50;
    localparam logic [16:0] LOW_FREQ_RST   = 17'd783;
    localparam logic [16:0] HIGH_FREQ_RST  = 17'd12622;
    localparam logic [2:0]  BAR_LEN_RST    = 3'd4;

endpackage

`default_nettype wire

// File: src/amts_div.sv
`default_nettype none

// Radix-2 restoring divider, one quotient bit per cycle.
// done pulses in the cycle after the last step; quotient holds until next start.
module amts_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [amts_pkg::QUO_W-1:0]  dividend,
    input  wire logic [amts_pkg::DVS_W-1:0]  divisor,
    output logic                             done,
    output logic [amts_pkg::QUO_W-1:0]       quotient
);

    logic                           busy_reg;
    logic                           done_reg;
    logic [amts_pkg::STEP_W-1:0]    step_reg;
    logic [amts_pkg::DVS_W-1:0]     rem_reg;
    logic [amts_pkg::DVS_W-1:0]     dvs_reg;
    logic [amts_pkg::QUO_W-1:0]     quo_reg;

    logic [amts_pkg::DVS_W:0]       trial;
    logic [amts_pkg::DVS_W:0]       diff;
    logic                           fits;
    logic                           last_step;

    // Trial subtract of the shifted partial remainder
    always_comb
    begin
        trial     = {rem_reg, quo_reg[amts_pkg::QUO_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        fits      = (trial >= {1'b0, dvs_reg});
        last_step = (step_reg == {amts_pkg::STEP_W{1'b1}});
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[amts_pkg::DVS_W-1:0] : trial[amts_pkg::DVS_W-1:0];
            quo_reg <= {quo_reg[amts_pkg::QUO_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: src/accented_metronome_tone_strobe.sv
`default_nettype none
// The shared 16-step divider runs twice per item (beat interval, then strobe length).
// Input is taken only while the sequencer is idle, so one item at a time; it is
//   taken again as soon as the sequencer is idle, even while the previous result
//   waits on out_ready.
// Reset: asynchronous active-low; configuration registers return to defaults, beat state cleared.

module accented_metronome_tone_strobe (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  advance_ms,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [16:0]      low_tone_out,
    output logic             low_tone_changed,
    output logic [16:0]      high_tone_out,
    output logic             high_tone_changed,
    output logic [7:0]       strobe_level,
    output logic             indicator_on,
    output logic [2:0]       beat_number
);

    // Configuration registers
    logic [9:0]  bpm_reg;
    logic [2:0]  meter_reg;
    logic [7:0]  strobe_div_reg;
    logic [16:0] low_freq_reg;
    logic [16:0] high_freq_reg;
    logic        low_en_reg;
    logic        high_en_reg;
    logic        strobe_en_reg;

    // Beat state
    logic [15:0] elapsed_reg;
    logic [2:0]  beat_reg;
    logic [2:0]  bar_len_reg;
    logic [16:0] last_low_reg;
    logic [16:0] last_high_reg;
    logic        known_reg;

    // Sequencer and per-item work registers
    amts_pkg::seq_state_t state_reg, state_next;
    logic [7:0]  adv_reg;
    logic [15:0] interval_reg;
    logic [15:0] pulse_len_reg;

    // Output registers
    logic        out_valid_reg;
    logic [16:0] low_out_reg;
    logic        low_chg_reg;
    logic [16:0] high_out_reg;
    logic        high_chg_reg;
    logic        light_reg;
    logic [2:0]  beat_out_reg;

    // Divider hookup
    logic                          div_start;
    logic [amts_pkg::QUO_W-1:0]    div_dividend;
    logic [amts_pkg::DVS_W-1:0]    div_divisor;
    logic                          div_done;
    logic [amts_pkg::QUO_W-1:0]    div_quotient;

    logic        cfg_write;
    logic        in_xfer;
    logic        emit;
    logic [9:0]  bpm_eff;
    logic [7:0]  div_eff;

    // Result computation
    logic [16:0] t_sum;
    logic [15:0] t_sat;
    logic        wrap;
    logic [15:0] elapsed_new;
    logic [2:0]  beat_inc;
    logic [2:0]  beat_new;
    logic        free_meter;
    logic        sound;
    logic        light;
    logic [16:0] low_val;
    logic [17:0] accent;
    logic [17:0] high_sum;
    logic [16:0] high_val;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign in_ready  = (state_reg == amts_pkg::ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign emit      = (state_reg == amts_pkg::ST_EMIT) && (!out_valid_reg || out_ready);

    assign bpm_eff = (bpm_reg == 10'd0) ? 10'd1 : bpm_reg;
    assign div_eff = (strobe_div_reg == 8'd0) ? 8'd1 : strobe_div_reg;

    amts_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Sequencer: interval = 60000 / bpm, then pulse = interval / divider
    always_comb
    begin
        state_next   = state_reg;
        div_start    = 1'b0;
        div_dividend = amts_pkg::MINUTE_MS;
        div_divisor  = bpm_eff;
        unique case (state_reg)
            amts_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    div_start  = 1'b1;
                    state_next = amts_pkg::ST_INTERVAL;
                end
            end
            amts_pkg::ST_INTERVAL:
            begin
                if (div_done)
                begin
                    div_start    = 1'b1;
                    div_dividend = div_quotient;
                    div_divisor  = {2'b00, div_eff};
                    state_next   = amts_pkg::ST_STROBE;
                end
            end
            amts_pkg::ST_STROBE:
            begin
                if (div_done)
                begin
                    state_next = amts_pkg::ST_EMIT;
                end
            end
            amts_pkg::ST_EMIT:
            begin
                if (emit)
                begin
                    state_next = amts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = amts_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= amts_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Per-item work registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            adv_reg <= advance_ms;
        end
        if (state_reg == amts_pkg::ST_INTERVAL && div_done)
        begin
            interval_reg <= div_quotient;
        end
        if (state_reg == amts_pkg::ST_STROBE && div_done)
        begin
            pulse_len_reg <= div_quotient;
        end
    end

    // Beat advance, gate, strobe and accent
    always_comb
    begin
        t_sum       = {1'b0, elapsed_reg} + {9'd0, adv_reg};
        t_sat       = t_sum[16] ? 16'hFFFF : t_sum[15:0];
        wrap        = (t_sat >= interval_reg);
        elapsed_new = wrap ? 16'd0 : t_sat;
        beat_inc    = beat_reg + 3'd1;
        if (!wrap)
        begin
            beat_new = beat_reg;
        end
        else if (beat_inc > bar_len_reg)
        begin
            beat_new = 3'd1;
        end
        else
        begin
            beat_new = beat_inc;
        end

        free_meter = (meter_reg == amts_pkg::METER_FREE);
        sound      = free_meter || (elapsed_new < {1'b0, interval_reg[15:1]});
        light      = !free_meter && strobe_en_reg && (elapsed_new < pulse_len_reg);

        low_val = (low_en_reg && sound) ? low_freq_reg : 17'd0;

        if (free_meter)
        begin
            accent = 18'd0;
        end
        else if (beat_new == 3'd1)
        begin
            accent = amts_pkg::ACCENT_ONE;
        end
        else if (meter_reg == amts_pkg::METER_SIX_EIGHT && beat_new == 3'd4)
        begin
            accent = amts_pkg::ACCENT_SIX;
        end
        else if (meter_reg == amts_pkg::METER_FOUR_FOUR && beat_new == 3'd3)
        begin
            accent = amts_pkg::ACCENT_THREE;
        end
        else
        begin
            accent = 18'd0;
        end
        high_sum = {1'b0, high_freq_reg} + accent;
        if (!(high_en_reg && sound))
        begin
            high_val = 17'd0;
        end
        else if (high_sum[17])
        begin
            high_val = amts_pkg::TONE_MAX;
        end
        else
        begin
            high_val = high_sum[16:0];
        end
    end

    // Configuration writes and beat state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpm_reg        <= amts_pkg::BPM_RST;
            meter_reg      <= amts_pkg::METER_FREE;
            strobe_div_reg <= amts_pkg::STROBE_DIV_RST;
            low_freq_reg   <= amts_pkg::LOW_FREQ_RST;
            high_freq_reg  <= amts_pkg::HIGH_FREQ_RST;
            low_en_reg     <= 1'b0;
            high_en_reg    <= 1'b0;
            strobe_en_reg  <= 1'b0;
            elapsed_reg    <= '0;
            beat_reg       <= '0;
            bar_len_reg    <= amts_pkg::BAR_LEN_RST;
            last_low_reg   <= '0;
            last_high_reg  <= '0;
            known_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (amts_pkg::cfg_index_t'(paddr[4:2]))
                    amts_pkg::REG_BPM:        bpm_reg        <= pwdata[9:0];
                    amts_pkg::REG_METER:
                    begin
                        meter_reg <= pwdata[2:0];
                        beat_reg  <= 3'd0;
                        case (pwdata[2:0])
                            amts_pkg::METER_FOUR_FOUR:  bar_len_reg <= 3'd4;
                            amts_pkg::METER_THREE_FOUR: bar_len_reg <= 3'd3;
                            amts_pkg::METER_SIX_EIGHT:  bar_len_reg <= 3'd6;
                            amts_pkg::METER_TWO_FOUR:   bar_len_reg <= 3'd2;
                            default:                    bar_len_reg <= bar_len_reg;
                        endcase
                    end
                    amts_pkg::REG_STROBE_DIV: strobe_div_reg <= pwdata[7:0];
                    amts_pkg::REG_LOW_FREQ:   low_freq_reg   <= pwdata[16:0];
                    amts_pkg::REG_HIGH_FREQ:  high_freq_reg  <= pwdata[16:0];
                    amts_pkg::REG_LOW_EN:     low_en_reg     <= pwdata[0];
                    amts_pkg::REG_HIGH_EN:    high_en_reg    <= pwdata[0];
                    amts_pkg::REG_STROBE_EN:  strobe_en_reg  <= pwdata[0];
                    default:                  bpm_reg        <= bpm_reg;
                endcase
            end
            if (emit)
            begin
                elapsed_reg   <= elapsed_new;
                beat_reg      <= beat_new;
                last_low_reg  <= low_val;
                last_high_reg <= high_val;
                known_reg     <= 1'b1;
            end
        end
    end

    // Register readback
    always_comb
    begin
        unique case (amts_pkg::cfg_index_t'(paddr[4:2]))
            amts_pkg::REG_BPM:        prdata = {22'd0, bpm_reg};
            amts_pkg::REG_METER:      prdata = {29'd0, meter_reg};
            amts_pkg::REG_STROBE_DIV: prdata = {24'd0, strobe_div_reg};
            amts_pkg::REG_LOW_FREQ:   prdata = {15'd0, low_freq_reg};
            amts_pkg::REG_HIGH_FREQ:  prdata = {15'd0, high_freq_reg};
            amts_pkg::REG_LOW_EN:     prdata = {31'd0, low_en_reg};
            amts_pkg::REG_HIGH_EN:    prdata = {31'd0, high_en_reg};
            amts_pkg::REG_STROBE_EN:  prdata = {31'd0, strobe_en_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    // Output register: valid control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register: payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            low_out_reg  <= low_val;
            low_chg_reg  <= !known_reg || (low_val != last_low_reg);
            high_out_reg <= high_val;
            high_chg_reg <= !known_reg || (high_val != last_high_reg);
            light_reg    <= light;
            beat_out_reg <= beat_new;
        end
    end

    assign out_valid         = out_valid_reg;
    assign low_tone_out      = low_out_reg;
    assign low_tone_changed  = low_chg_reg;
    assign high_tone_out     = high_out_reg;
    assign high_tone_changed = high_chg_reg;
    assign strobe_level      = light_reg ? amts_pkg::STROBE_DUTY : 8'd0;
    assign indicator_on      = light_reg;
    assign beat_number       = beat_out_reg;

endmodule

`default_nettype wire

// File: tb/accented_metronome_tone_strobe_checker.sv
module accented_metronome_tone_strobe_checker (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,

    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  advance_ms,

    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [16:0] low_tone_out,
    input  logic        low_tone_changed,
    input  logic [16:0] high_tone_out,
    input  logic        high_tone_changed,
    input  logic [7:0]  strobe_level,
    input  logic        indicator_on,
    input  logic [2:0]  beat_number,

    output int          error_count,
    output int          pending_results
);

    // Timing and tone numbers of the metronome
    localparam int unsigned MS_PER_MINUTE    = 60000;
    localparam int unsigned DOWNBEAT_ACCENT  = 15000;
    localparam int unsigned SIX_EIGHT_ACCENT = 7000;
    localparam int unsigned FOUR_FOUR_ACCENT = 4000;
    localparam int unsigned TONE_CEILING     = 131071;
    localparam int unsigned ELAPSED_CEILING  = 65535;
    localparam logic [7:0]  FLASH_DUTY       = 8'd150;

    typedef struct packed {
        logic [16:0] low_tone;
        logic        low_changed;
        logic [16:0] high_tone;
        logic        high_changed;
        logic [7:0]  strobe;
        logic        lamp;
        logic [2:0]  beat;
    } tone_frame_t;

    // Register copies
    logic [9:0]  cfg_bpm;
    logic [2:0]  cfg_meter;
    logic [7:0]  cfg_divider;
    logic [16:0] cfg_low_freq;
    logic [16:0] cfg_high_freq;
    logic        cfg_low_en;
    logic        cfg_high_en;
    logic        cfg_strobe_en;

    // Beat state
    logic [15:0] beat_elapsed;
    logic [2:0]  bar_pos;
    logic [2:0]  bar_len;
    logic [16:0] last_low;
    logic [16:0] last_high;
    logic        tones_known;

    tone_frame_t expected_frames[$];
    tone_frame_t want;
    int          result_count;

    // Works out the outputs of one millisecond report and queues them
    task automatic advance_metronome(input logic [7:0] ms);
        int unsigned tempo;
        int unsigned divisor;
        int unsigned interval;
        int unsigned sum;
        int unsigned low;
        int unsigned high;
        logic        sound;
        logic        light;
        tone_frame_t frame;

        tempo    = (cfg_bpm == 10'd0) ? 1 : cfg_bpm;
        divisor  = (cfg_divider == 8'd0) ? 1 : cfg_divider;
        interval = MS_PER_MINUTE / tempo;

        sum = beat_elapsed + ms;
        if (sum > ELAPSED_CEILING)
            sum = ELAPSED_CEILING;
        beat_elapsed = 16'(sum);

        // new beat: clear time, step through the bar
        if (beat_elapsed >= interval)
        begin
            beat_elapsed = 16'd0;
            bar_pos = bar_pos + 3'd1;
            if (bar_pos > bar_len)
                bar_pos = 3'd1;
        end

        sound = (cfg_meter == amts_pkg::METER_FREE) || (beat_elapsed < interval / 2);
        light = (cfg_meter != amts_pkg::METER_FREE) && cfg_strobe_en &&
                (beat_elapsed < interval / divisor);

        low = (cfg_low_en && sound) ? cfg_low_freq : 0;

        high = 0;
        if (cfg_high_en && sound)
        begin
            high = cfg_high_freq;
            if (cfg_meter != amts_pkg::METER_FREE)
            begin
                if (bar_pos == 3'd1)
                    high += DOWNBEAT_ACCENT;
                else if (cfg_meter == amts_pkg::METER_SIX_EIGHT && bar_pos == 3'd4)
                    high += SIX_EIGHT_ACCENT;
                else if (cfg_meter == amts_pkg::METER_FOUR_FOUR && bar_pos == 3'd3)
                    high += FOUR_FOUR_ACCENT;
            end
            if (high > TONE_CEILING)
                high = TONE_CEILING;
        end

        frame.low_tone     = 17'(low);
        frame.low_changed  = !tones_known || (17'(low) != last_low);
        frame.high_tone    = 17'(high);
        frame.high_changed = !tones_known || (17'(high) != last_high);
        frame.strobe       = light ? FLASH_DUTY : 8'd0;
        frame.lamp         = light;
        frame.beat         = bar_pos;

        last_low    = 17'(low);
        last_high   = 17'(high);
        tones_known = 1'b1;
        expected_frames.push_back(frame);
    endtask

    task automatic check_field(input string field, input int unsigned expected_value,
                               input int unsigned actual_value);
        if (expected_value != actual_value)
        begin
            error_count++;
            if (error_count <= 10)
                $display("result %0d: %s expected %0d, got %0d",
                         result_count, field, expected_value, actual_value);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_bpm       = amts_pkg::BPM_RST;
            cfg_meter     = amts_pkg::METER_FREE;
            cfg_divider   = amts_pkg::STROBE_DIV_RST;
            cfg_low_freq  = 17'd783;
            cfg_high_freq = 17'd12622;
            cfg_low_en    = 1'b0;
            cfg_high_en   = 1'b0;
            cfg_strobe_en = 1'b0;
            beat_elapsed  = 16'd0;
            bar_pos       = 3'd0;
            bar_len       = 3'd4;
            last_low      = 17'd0;
            last_high     = 17'd0;
            tones_known   = 1'b0;
            result_count  = 0;
            expected_frames.delete();
            pending_results = 0;
        end
        else
        begin
            // result transfer: compare against the oldest prediction
            if (out_valid && out_ready)
            begin
                if (expected_frames.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("result %0d arrived with nothing expected", result_count);
                end
                else
                begin
                    want = expected_frames.pop_front();
                    check_field("low_tone_out", want.low_tone, low_tone_out);
                    check_field("low_tone_changed", want.low_changed, low_tone_changed);
                    check_field("high_tone_out", want.high_tone, high_tone_out);
                    check_field("high_tone_changed", want.high_changed, high_tone_changed);
                    check_field("strobe_level", want.strobe, strobe_level);
                    check_field("indicator_on", want.lamp, indicator_on);
                    check_field("beat_number", want.beat, beat_number);
                end
                result_count++;
            end

            // input transfer
            if (in_valid && in_ready)
                advance_metronome(advance_ms);

            // register write
            if (psel && penable && pwrite && pready)
            begin
                case (amts_pkg::cfg_index_t'(paddr[4:2]))
                    amts_pkg::REG_BPM:        cfg_bpm = pwdata[9:0];
                    amts_pkg::REG_METER:
                    begin
                        cfg_meter = pwdata[2:0];
                        bar_pos   = 3'd0;
                        case (cfg_meter)
                            amts_pkg::METER_FOUR_FOUR:  bar_len = 3'd4;
                            amts_pkg::METER_THREE_FOUR: bar_len = 3'd3;
                            amts_pkg::METER_SIX_EIGHT:  bar_len = 3'd6;
                            amts_pkg::METER_TWO_FOUR:   bar_len = 3'd2;
                            default:                    ;
                        endcase
                    end
                    amts_pkg::REG_STROBE_DIV: cfg_divider   = pwdata[7:0];
                    amts_pkg::REG_LOW_FREQ:   cfg_low_freq  = pwdata[16:0];
                    amts_pkg::REG_HIGH_FREQ:  cfg_high_freq = pwdata[16:0];
                    amts_pkg::REG_LOW_EN:     cfg_low_en    = pwdata[0];
                    amts_pkg::REG_HIGH_EN:    cfg_high_en   = pwdata[0];
                    amts_pkg::REG_STROBE_EN:  cfg_strobe_en = pwdata[0];
                    default:                  ;
                endcase
            end

            pending_results = expected_frames.size();
        end
    end

endmodule

// File: tb/accented_metronome_tone_strobe_tb.sv
module accented_metronome_tone_strobe_tb;

    // meter code outside the listed set
    localparam logic [2:0] METER_SPARE = 3'd5;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  advance_ms;
    logic        out_valid;
    logic        out_ready;
    logic [16:0] low_tone_out;
    logic        low_tone_changed;
    logic [16:0] high_tone_out;
    logic        high_tone_changed;
    logic [7:0]  strobe_level;
    logic        indicator_on;
    logic [2:0]  beat_number;

    int error_count;
    int pending_results;
    int ticks_sent;
    bit idle_en;
    bit long_hold;

    accented_metronome_tone_strobe uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .advance_ms        (advance_ms),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .low_tone_out      (low_tone_out),
        .low_tone_changed  (low_tone_changed),
        .high_tone_out     (high_tone_out),
        .high_tone_changed (high_tone_changed),
        .strobe_level      (strobe_level),
        .indicator_on      (indicator_on),
        .beat_number       (beat_number)
    );

    accented_metronome_tone_strobe_checker beat_monitor (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .pready            (pready),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .advance_ms        (advance_ms),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .low_tone_out      (low_tone_out),
        .low_tone_changed  (low_tone_changed),
        .high_tone_out     (high_tone_out),
        .high_tone_changed (high_tone_changed),
        .strobe_level      (strobe_level),
        .indicator_on      (indicator_on),
        .beat_number       (beat_number),
        .error_count       (error_count),
        .pending_results   (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Setup and access cycle; caller sits at a falling edge
    task automatic write_reg(input amts_pkg::cfg_index_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One millisecond report, with an optional idle burst ahead of it
    task automatic send_tick(input logic [7:0] ms);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9))
                @(negedge clk);
        end
        in_valid   <= 1'b1;
        advance_ms <= ms;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        ticks_sent++;
        @(negedge clk);
    endtask

    // Block is idle once every predicted result has been taken
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
    endtask

    // Receiver: random stall bursts, plus the long hold-off
    initial
    begin
        int gap;
        gap = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
                out_ready <= 1'b0;
            else if (gap > 0)
            begin
                out_ready <= 1'b0;
                gap--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (idle_en && $urandom_range(0, 5) == 0)
                    gap = $urandom_range(1, 9);
            end
        end
    end

    // Long receiver hold-off so the block backs up into its input
    initial
    begin
        long_hold = 1'b0;
        wait (ticks_sent >= 400);
        @(posedge clk);
        long_hold = 1'b1;
        repeat (400)
            @(posedge clk);
        long_hold = 1'b0;
    end

    initial
    begin
        #20000000;
        $display("[accented_metronome_tone_strobe] ERROR");
        $finish;
    end

    initial
    begin
        int          phase;
        int          count;
        int          settle;
        logic [31:0] value;
        logic [7:0]  ms;

        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = 5'd0;
        pwdata     = 32'd0;
        in_valid   = 1'b0;
        advance_ms = 8'd0;
        idle_en    = 1'b1;
        ticks_sent = 0;

        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // defaults: both change flags set on the first result, quiet free meter
        send_tick(8'd0);
        send_tick(8'hFF);
        send_tick(8'hFF);
        drain();

        // 4/4 at 600 bpm, accented tone saturates, beat three accent
        write_reg(amts_pkg::REG_BPM, 32'd600);
        write_reg(amts_pkg::REG_METER, 32'(amts_pkg::METER_FOUR_FOUR));
        write_reg(amts_pkg::REG_STROBE_DIV, 32'd2);
        write_reg(amts_pkg::REG_LOW_FREQ, 32'd100000);
        write_reg(amts_pkg::REG_HIGH_FREQ, 32'd120000);
        write_reg(amts_pkg::REG_LOW_EN, 32'd1);
        write_reg(amts_pkg::REG_HIGH_EN, 32'd1);
        write_reg(amts_pkg::REG_STROBE_EN, 32'd1);
        repeat (4)
            send_tick(8'd100);
        send_tick(8'd30);
        send_tick(8'd30);
        drain();

        // zero tempo and zero divider fall back to one
        write_reg(amts_pkg::REG_BPM, 32'd0);
        write_reg(amts_pkg::REG_STROBE_DIV, 32'd0);
        write_reg(amts_pkg::REG_METER, 32'(amts_pkg::METER_SIX_EIGHT));
        send_tick(8'hFF);
        send_tick(8'hFF);
        drain();

        // 6/8 with the beat four accent
        write_reg(amts_pkg::REG_BPM, 32'd1023);
        repeat (5)
            send_tick(8'd58);
        drain();

        // free meter keeps the old bar length and blocks the strobe
        write_reg(amts_pkg::REG_METER, 32'(amts_pkg::METER_FREE));
        repeat (7)
            send_tick(8'hFF);
        drain();

        // unlisted meter acts as a plain non-free meter
        write_reg(amts_pkg::REG_METER, 32'(METER_SPARE));
        send_tick(8'd58);
        send_tick(8'd20);

        // random settings, each followed by a burst of reports
        for (phase = 0; phase < 12; phase++)
        begin
            drain();
            if (phase >= 10)
                idle_en = 1'b0;

            case ($urandom_range(0, 9))
                0:       value = 32'd0;
                1:       value = 32'd1;
                2:       value = 32'd600;
                3:       value = 32'd1023;
                4:       value = $urandom_range(1, 59);
                default: value = $urandom_range(60, 600);
            endcase
            write_reg(amts_pkg::REG_BPM, value);

            if ($urandom_range(0, 3) != 0)
            begin
                if ($urandom_range(0, 3) == 0)
                    value = $urandom_range(0, 7);
                else
                    value = $urandom_range(0, 4);
                write_reg(amts_pkg::REG_METER, value);
            end

            case ($urandom_range(0, 5))
                0:       value = 32'd0;
                1:       value = 32'd1;
                2:       value = 32'd255;
                default: value = $urandom_range(1, 255);
            endcase
            write_reg(amts_pkg::REG_STROBE_DIV, value);

            case ($urandom_range(0, 5))
                0:       value = 32'd0;
                1:       value = 32'd100000;
                2:       value = 32'd131071;
                default: value = $urandom_range(0, 100000);
            endcase
            write_reg(amts_pkg::REG_LOW_FREQ, value);

            case ($urandom_range(0, 5))
                0:       value = 32'd0;
                1:       value = 32'd100000;
                2:       value = 32'd131071;
                default: value = $urandom_range(0, 100000);
            endcase
            write_reg(amts_pkg::REG_HIGH_FREQ, value);

            write_reg(amts_pkg::REG_LOW_EN, 32'($urandom_range(0, 3) != 0));
            write_reg(amts_pkg::REG_HIGH_EN, 32'($urandom_range(0, 3) != 0));
            write_reg(amts_pkg::REG_STROBE_EN, 32'($urandom_range(0, 3) != 0));

            count = $urandom_range(100, 150);
            repeat (count)
            begin
                case ($urandom_range(0, 9))
                    0:       ms = 8'd0;
                    1:       ms = 8'hFF;
                    2, 3:    ms = 8'($urandom_range(0, 15));
                    default: ms = 8'($urandom_range(0, 255));
                endcase
                send_tick(ms);
            end
        end

        // let the last results come out, then a short quiet spell
        in_valid <= 1'b0;
        settle = 0;
        while (pending_results != 0 && settle < 5000)
        begin
            @(negedge clk);
            settle++;
        end
        repeat (50)
            @(negedge clk);

        if (error_count == 0 && pending_results == 0)
            $display("[accented_metronome_tone_strobe] OK");
        else
            $display("[accented_metronome_tone_strobe] ERROR");
        $finish;
    end

endmodule

// File: accented_metronome_tone_strobe.f
src/amts_pkg.sv
src/amts_div.sv
src/accented_metronome_tone_strobe.sv
tb/accented_metronome_tone_strobe_checker.sv
tb/accented_metronome_tone_strobe_tb.sv
